// ===== design/lbfit_pkg.sv =====
// Shared types and default sizes for the letterbox fit pipeline.
package lbfit_pkg;

  localparam int DIM_BITS_DEF = 16;

  typedef enum logic [1:0] {
    FIT_FULL   = 2'b00,
    FIT_HEIGHT = 2'b01,
    FIT_WIDTH  = 2'b10
  } fit_mode_t;

endpackage

// ===== design/letterbox_fit_rect_core.sv =====
// Letterbox fit: largest centered rectangle inside a destination at the source aspect.
//
// Channel   Dir  Width (DIM_BITS=16)  Contents, lowest bits first
// s_axis    in   64                   src_width, src_height, dst_width, dst_height
// m_axis    out  64                   offset_x, offset_y, fit_width, fit_height, zero pad
//
// One item enters per cycle while the output is taken.
// The restoring divider resolves one quotient bit per stage.
// Every stage holds its own valid bit, so an empty stage is filled even while later
// stages wait, and a stalled stage keeps its item until the next stage takes it.
// Reset clears all valid bits; the data registers are not reset.
module letterbox_fit_rect_core
  import lbfit_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // src_width, src_height, dst_width, dst_height
  input  logic [((4*DIM_BITS+7)/8)*8-1:0]          s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // offset_x, offset_y, fit_width, fit_height, zero pad
  output logic [((4*DIM_BITS-2+7)/8)*8-1:0]        m_tdata
);

  localparam int D      = DIM_BITS;
  localparam int OUT_W  = ((4*DIM_BITS-2+7)/8)*8;
  localparam int PAD_W  = OUT_W - (4*DIM_BITS-2);

  // Input stage.
  logic             v0;
  logic [D-1:0]     sw0, sh0, dw0, dh0;
  // Product stage.
  logic             v1;
  logic [2*D-1:0]   src_cross1, dst_cross1;
  logic [D-1:0]     sw1, sh1, dw1, dh1;
  // Divider stages; index 0 holds the selected operands, index D the quotient.
  logic             dv     [0:D];
  logic [D-1:0]     d_rem  [0:D];
  logic [D-1:0]     d_low  [0:D];
  logic [D-1:0]     d_div  [0:D];
  fit_mode_t        d_mode [0:D];
  logic [D-1:0]     d_dw   [0:D];
  logic [D-1:0]     d_dh   [0:D];
  logic             dr     [0:D];
  // Output stage.
  logic             vo;
  logic [D-2:0]     off_x, off_y;
  logic [D-1:0]     fit_w, fit_h;
  logic [D-1:0]     dw_o, dh_o;

  logic             ro, r1, r0;

  assign ro       = !vo || m_tready;
  assign r1       = !v1 || dr[0];
  assign r0       = !v0 || r1;
  assign s_tready = r0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && s_tvalid) begin
      sw0 <= s_tdata[D-1:0];
      sh0 <= s_tdata[2*D-1:D];
      dw0 <= s_tdata[3*D-1:2*D];
      dh0 <= s_tdata[4*D-1:3*D];
    end
  end

  // Cross products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      src_cross1 <= (2*D)'(sw0) * (2*D)'(dh0);
      dst_cross1 <= (2*D)'(dw0) * (2*D)'(sh0);
      sw1        <= sw0;
      sh1        <= sh0;
      dw1        <= dw0;
      dh1        <= dh0;
    end
  end

  // Operand selection.
  logic [2*D-1:0] dividend_next;
  logic [D-1:0]   divisor_next;
  fit_mode_t      mode_next;

  always_comb begin
    if (src_cross1 > dst_cross1) begin
      mode_next     = FIT_HEIGHT;
      dividend_next = dst_cross1;
      divisor_next  = sw1;
    end else if (src_cross1 < dst_cross1) begin
      mode_next     = FIT_WIDTH;
      dividend_next = src_cross1;
      divisor_next  = sh1;
    end else begin
      mode_next     = FIT_FULL;
      dividend_next = '0;
      divisor_next  = sw1;
    end
  end

  assign dr[D] = !dv[D] || ro;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (dr[0]) begin
      dv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (dr[0] && v1) begin
      d_rem[0]  <= dividend_next[2*D-1:D];
      d_low[0]  <= dividend_next[D-1:0];
      d_div[0]  <= divisor_next;
      d_mode[0] <= mode_next;
      d_dw[0]   <= dw1;
      d_dh[0]   <= dh1;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= D; k++) begin : g_div
    logic [D:0] trial;
    logic [D:0] diff;
    logic       ge;

    assign dr[k-1] = !dv[k-1] || dr[k];
    assign trial   = {d_rem[k-1], d_low[k-1][D-1]};
    assign diff    = trial - {1'b0, d_div[k-1]};
    assign ge      = !diff[D];

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (dr[k]) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (dr[k] && dv[k-1]) begin
        d_rem[k]  <= ge ? diff[D-1:0] : trial[D-1:0];
        d_low[k]  <= {d_low[k-1][D-2:0], ge};
        d_div[k]  <= d_div[k-1];
        d_mode[k] <= d_mode[k-1];
        d_dw[k]   <= d_dw[k-1];
        d_dh[k]   <= d_dh[k-1];
      end
    end
  end

  // Fitted extent and centering offsets.
  logic [D-1:0] fw_next, fh_next, left_w, left_h;

  always_comb begin
    fw_next = d_dw[D];
    fh_next = d_dh[D];
    if (d_mode[D] == FIT_WIDTH) begin
      fw_next = (d_low[D] > d_dw[D]) ? d_dw[D] : d_low[D];
    end
    if (d_mode[D] == FIT_HEIGHT) begin
      fh_next = (d_low[D] > d_dh[D]) ? d_dh[D] : d_low[D];
    end
    left_w = d_dw[D] - fw_next;
    left_h = d_dh[D] - fh_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (ro) begin
      vo <= dv[D];
    end
  end

  always_ff @(posedge clk) begin
    if (ro && dv[D]) begin
      off_x <= left_w[D-1:1];
      off_y <= left_h[D-1:1];
      fit_w <= fw_next;
      fit_h <= fh_next;
      dw_o  <= d_dw[D];
      dh_o  <= d_dh[D];
    end
  end

  assign m_tvalid = vo;
  if (PAD_W > 0) begin : g_pad
    assign m_tdata = {{PAD_W{1'b0}}, fit_h, fit_w, off_y, off_x};
  end else begin : g_nopad
    assign m_tdata = {fit_h, fit_w, off_y, off_x};
  end

  // The chosen divisor is never zero when a division is needed.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    dv[0] && d_mode[0] != FIT_FULL |-> d_div[0] != '0)
    else $error("zero divisor selected");

  // The upper dividend half is below the divisor, so the quotient fits DIM_BITS.
  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    dv[0] && d_mode[0] != FIT_FULL |-> d_rem[0] < d_div[0])
    else $error("quotient overflows");

  // In width fit mode the quotient never exceeds the destination width it fits into.
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    dv[D] && d_mode[D] == FIT_WIDTH |-> d_low[D] <= d_dw[D])
    else $error("fitted width beyond destination");

  // One axis always fills the destination.
  a_one_axis_full: assert property (@(posedge clk) disable iff (rst)
    vo |-> (fit_w == dw_o) || (fit_h == dh_o))
    else $error("no axis fills the destination");

endmodule

// ===== bench/letterbox_fit_rect_core_tb.sv =====
// Self-checking stream testbench for the letterbox fit core, directed rows then random sizes.
module letterbox_fit_rect_core_tb
  import lbfit_pkg::*;
();

  localparam int DIM = DIM_BITS_DEF;
  localparam int IN_W = ((4*DIM+7)/8)*8;
  localparam int OUT_W = ((4*DIM-2+7)/8)*8;
  localparam int PAD_W = OUT_W - (4*DIM-2);
  localparam int LATENCY = DIM + 4;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_ROWS = 19;
  localparam int N_RES = 8;

  typedef struct packed {
    logic [DIM-1:0] dst_height;
    logic [DIM-1:0] dst_width;
    logic [DIM-1:0] src_height;
    logic [DIM-1:0] src_width;
  } sizes_t;

  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic [DIM-1:0]   fit_height;
    logic [DIM-1:0]   fit_width;
    logic [DIM-2:0]   offset_y;
    logic [DIM-2:0]   offset_x;
  } rect_t;

  typedef struct {
    int sw, sh, dw, dh;
    bit typed;
    int ox, oy, fw, fh;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // src_width, src_height, dst_width, dst_height
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // offset_x, offset_y, fit_width, fit_height, zero pad
  logic [OUT_W-1:0] m_tdata;

  rect_t fit_expected[$];
  bit cur_typed_on = 1'b0;
  rect_t cur_typed = '0;
  bit quiet = 1'b0;
  int errors = 0;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  rect_t want, got;

  int res_w [N_RES] = '{3840, 1920, 1280, 720, 640, 1080, 2560, 1024};
  int res_h [N_RES] = '{2160, 1080, 720, 576, 480, 1920, 1080, 768};

  row_t dir_rows [N_ROWS] = '{
    '{0, 0, 0, 0,             1, 0, 0, 0, 0},
    '{65535, 65535, 65535, 65535, 1, 0, 0, 65535, 65535},
    '{1920, 1080, 1920, 1080, 1, 0, 0, 1920, 1080},
    '{0, 5, 100, 50,          1, 50, 0, 0, 50},
    '{5, 0, 100, 50,          1, 0, 25, 100, 0},
    '{0, 0, 640, 480,         1, 0, 0, 640, 480},
    '{4, 3, 0, 100,           1, 0, 50, 0, 0},
    '{4, 3, 100, 0,           1, 50, 0, 0, 0},
    '{65535, 1, 65535, 65535, 1, 0, 32767, 65535, 1},
    '{1, 65535, 65535, 65535, 1, 32767, 0, 1, 65535},
    '{65535, 65535, 1, 1,     1, 0, 0, 1, 1},
    '{1, 1, 65535, 0,         1, 32767, 0, 0, 0},
    '{1, 0, 0, 0,             1, 0, 0, 0, 0},
    '{0, 0, 65535, 65535,     1, 0, 0, 65535, 65535},
    '{1920, 1080, 1000, 1000, 0, 0, 0, 0, 0},
    '{1080, 1920, 1000, 1000, 0, 0, 0, 0, 0},
    '{640, 480, 1920, 1080,   0, 0, 0, 0, 0},
    '{3, 2, 65535, 65535,     0, 0, 0, 0, 0},
    '{7, 3, 10, 10,           0, 0, 0, 0, 0}
  };

  letterbox_fit_rect_core #(
    .DIM_BITS(DIM)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #6 clk = ~clk;

  function automatic rect_t fit_rect(sizes_t s);
    logic [2*DIM-1:0] src_cross;
    logic [2*DIM-1:0] dst_cross;
    logic [2*DIM-1:0] fw;
    logic [2*DIM-1:0] fh;
    logic [DIM-1:0] left_w;
    logic [DIM-1:0] left_h;
    fit_mode_t mode;
    rect_t r;
    src_cross = (2*DIM)'(s.src_width) * (2*DIM)'(s.dst_height);
    dst_cross = (2*DIM)'(s.dst_width) * (2*DIM)'(s.src_height);
    if (src_cross > dst_cross) begin
      mode = FIT_HEIGHT;
    end else if (src_cross < dst_cross) begin
      mode = FIT_WIDTH;
    end else begin
      mode = FIT_FULL;
    end
    fw = (2*DIM)'(s.dst_width);
    fh = (2*DIM)'(s.dst_height);
    case (mode)
      FIT_HEIGHT: begin
        fh = dst_cross / (2*DIM)'(s.src_width);
      end
      FIT_WIDTH: begin
        fw = src_cross / (2*DIM)'(s.src_height);
      end
      default: begin
      end
    endcase
    if (fw > (2*DIM)'(s.dst_width)) fw = (2*DIM)'(s.dst_width);
    if (fh > (2*DIM)'(s.dst_height)) fh = (2*DIM)'(s.dst_height);
    r = '0;
    r.fit_width = fw[DIM-1:0];
    r.fit_height = fh[DIM-1:0];
    left_w = s.dst_width - fw[DIM-1:0];
    left_h = s.dst_height - fh[DIM-1:0];
    r.offset_x = left_w[DIM-1:1];
    r.offset_y = left_h[DIM-1:1];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIM-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return DIM'(1);
      2: return {DIM{1'b1}} - DIM'(1);
      3: return {DIM{1'b1}};
      default: return DIM'($urandom);
    endcase
  endfunction

  function automatic sizes_t random_sizes();
    sizes_t s;
    int a, b, k1, k2, i, j;
    s = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      3, 4: begin
        s.src_width = DIM'($urandom_range(1, 64));
        s.src_height = DIM'($urandom_range(1, 64));
        s.dst_width = DIM'($urandom_range(1, 64));
        s.dst_height = DIM'($urandom_range(1, 64));
      end
      5, 8: begin
        a = $urandom_range(1, 255);
        b = $urandom_range(1, 255);
        k1 = $urandom_range(1, 255);
        k2 = $urandom_range(1, 255);
        s.src_width = DIM'(a * k1);
        s.src_height = DIM'(b * k1);
        s.dst_width = DIM'(a * k2);
        s.dst_height = DIM'(b * k2);
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 3))
            0: s.src_width = s.src_width + DIM'(1);
            1: s.src_height = s.src_height - DIM'(1);
            2: s.dst_width = s.dst_width - DIM'(1);
            default: s.dst_height = s.dst_height + DIM'(1);
          endcase
        end
      end
      6: begin
        i = $urandom_range(0, N_RES - 1);
        j = $urandom_range(0, N_RES - 1);
        s.src_width = DIM'(res_w[i]);
        s.src_height = DIM'(res_h[i]);
        s.dst_width = DIM'(res_w[j]);
        s.dst_height = DIM'(res_h[j]);
      end
      7: begin
        if ($urandom_range(0, 1)) s.src_width = '0;
        if ($urandom_range(0, 1)) s.src_height = '0;
        if ($urandom_range(0, 1)) s.dst_width = '0;
        if ($urandom_range(0, 1)) s.dst_height = '0;
      end
      9: begin
        s.src_width = pick_extreme();
        s.src_height = pick_extreme();
        s.dst_width = pick_extreme();
        s.dst_height = pick_extreme();
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic send_item(sizes_t item, bit typed_on, rect_t typed_rect);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= item;
    cur_typed_on <= typed_on;
    cur_typed <= typed_rect;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (fit_expected.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        fit_expected.push_back(cur_typed_on ? cur_typed : fit_rect(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (fit_expected.size() == 0) begin
          $error("result with no item outstanding: %h", m_tdata);
          errors++;
        end else begin
          want = fit_expected.pop_front();
          got = m_tdata;
          check_field("offset_x", 32'(want.offset_x), 32'(got.offset_x));
          check_field("offset_y", 32'(want.offset_y), 32'(got.offset_y));
          check_field("fit_width", 32'(want.fit_width), 32'(got.fit_width));
          check_field("fit_height", 32'(want.fit_height), 32'(got.fit_height));
          check_field("pad", 32'(want.pad), 32'(got.pad));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 15) begin
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sizes_t item;
    rect_t typed;
    row_t row;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_ROWS; i++) begin
      row = dir_rows[i];
      item.src_width = DIM'(row.sw);
      item.src_height = DIM'(row.sh);
      item.dst_width = DIM'(row.dw);
      item.dst_height = DIM'(row.dh);
      typed = '0;
      typed.offset_x = (DIM-1)'(row.ox);
      typed.offset_y = (DIM-1)'(row.oy);
      typed.fit_width = DIM'(row.fw);
      typed.fit_height = DIM'(row.fh);
      send_item(item, row.typed, typed);
    end
    wait_drained();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet <= ((n / 160) % 5 == 4);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_item(random_sizes(), 1'b0, '0);
    end
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
